// ===== sv/dist_pkg.sv =====
// ----------------------------------------------------------------------------
// dist_pkg
// Shared types, constants and rounding helpers of the distortion channel.
// ----------------------------------------------------------------------------
package dist_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int CH_BITS      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CH_IN_BITS   = 3;
    localparam int CFG_BITS     = 16;

    // Q.15 coefficients
    localparam int PRE_X_COEF  = 32604;
    localparam int PRE_P_COEF  = 164;
    localparam int UNITY_Q15   = 32768;
    localparam int GAIN_SLOPE  = 24;
    localparam int CLIP_LIMIT  = 14418;
    localparam int ALPHA_SLOPE = 26214;
    localparam int ALPHA_BASE  = 6554;
    localparam int SMP_MAX     = 2 ** (SAMPLE_BITS - 1) - 1;
    localparam int SMP_MIN     = -(2 ** (SAMPLE_BITS - 1));

    // multiplier operand and product widths
    localparam int MUL_A_BITS = 17;
    localparam int MUL_B_BITS = 23;
    localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
    localparam int SUM_BITS   = PROD_BITS + 1;
    localparam int RND_BITS   = SUM_BITS - 15;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [CH_BITS-1:0]            ch_addr_t;

    typedef enum logic [1:0] {
        CFG_DRIVE = 2'd0,
        CFG_TONE  = 2'd1,
        CFG_LEVEL = 2'd2
    } cfg_index_t;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_M1   = 10'b00_0000_0010,
        ST_M2   = 10'b00_0000_0100,
        ST_M3   = 10'b00_0000_1000,
        ST_M4   = 10'b00_0001_0000,
        ST_M5   = 10'b00_0010_0000,
        ST_M6   = 10'b00_0100_0000,
        ST_M7   = 10'b00_1000_0000,
        ST_M8   = 10'b01_0000_0000,
        ST_OUT  = 10'b10_0000_0000
    } dist_state_t;

    typedef struct packed {
        dist_state_t state;
        logic        accept;
    } dist_ctrl_t;

    typedef struct packed {
        logic     pre_we;
        logic     tone_we;
        ch_addr_t addr;
        sample_t  data;
    } dist_mem_wr_t;

    // round to nearest, ties up: add 2^14, floor-shift by 15
    function automatic logic signed [RND_BITS-1:0] round_q15(
        input logic signed [SUM_BITS-1:0] v
    );
        logic signed [SUM_BITS-1:0] s;
        s = v + SUM_BITS'(16384);
        return s[SUM_BITS-1:15];
    endfunction

    function automatic sample_t sat_sample(input logic signed [RND_BITS-1:0] v);
        sample_t r;
        if (v > RND_BITS'(SMP_MAX))
            r = SAMPLE_BITS'(SMP_MAX);
        else if (v < RND_BITS'(SMP_MIN))
            r = SAMPLE_BITS'(SMP_MIN);
        else
            r = v[SAMPLE_BITS-1:0];
        return r;
    endfunction

endpackage

// ===== sv/dist_mem.sv =====
// ----------------------------------------------------------------------------
// dist_mem
// Per-channel pre-filter and tone-filter memories with a registered read.
// ----------------------------------------------------------------------------
module dist_mem (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  dist_pkg::ch_addr_t    rd_addr,
    input  dist_pkg::dist_mem_wr_t wr,
    output dist_pkg::sample_t     pre_rdata,
    output dist_pkg::sample_t     tone_rdata
);

    dist_pkg::sample_t pre_mem  [dist_pkg::MAX_CHANNELS];
    dist_pkg::sample_t tone_mem [dist_pkg::MAX_CHANNELS];

    logic [dist_pkg::MAX_CHANNELS-1:0] pre_vld_reg;
    logic [dist_pkg::MAX_CHANNELS-1:0] tone_vld_reg;
    dist_pkg::sample_t                 pre_q_reg;
    dist_pkg::sample_t                 tone_q_reg;
    logic                              pre_qv_reg;
    logic                              tone_qv_reg;

    always_ff @(posedge clk)
    begin
        if (wr.pre_we)
        begin
            pre_mem[wr.addr] <= wr.data;
        end
        if (wr.tone_we)
        begin
            tone_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            pre_q_reg  <= pre_mem[rd_addr];
            tone_q_reg <= tone_mem[rd_addr];
        end
    end

    // entries not yet written since reset read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg  <= '0;
            tone_vld_reg <= '0;
            pre_qv_reg   <= 1'b0;
            tone_qv_reg  <= 1'b0;
        end
        else
        begin
            if (wr.pre_we)
            begin
                pre_vld_reg[wr.addr] <= 1'b1;
            end
            if (wr.tone_we)
            begin
                tone_vld_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                pre_qv_reg  <= pre_vld_reg[rd_addr];
                tone_qv_reg <= tone_vld_reg[rd_addr];
            end
        end
    end

    assign pre_rdata  = pre_qv_reg  ? pre_q_reg  : '0;
    assign tone_rdata = tone_qv_reg ? tone_q_reg : '0;

endmodule

// ===== sv/dist_datapath.sv =====
// ----------------------------------------------------------------------------
// dist_datapath
// Settings registers and the shared multiplier with its accumulate steps.
// ----------------------------------------------------------------------------
module dist_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [dist_pkg::CFG_BITS-1:0]  cfg_wdata,
    input  dist_pkg::dist_ctrl_t           ctrl,
    input  logic [dist_pkg::CH_IN_BITS-1:0] in_channel,
    input  dist_pkg::sample_t              in_sample,
    input  dist_pkg::sample_t              pre_rdata,
    input  dist_pkg::sample_t              tone_rdata,
    output dist_pkg::dist_mem_wr_t         wr,
    output dist_pkg::sample_t              result
);

    localparam int PB = dist_pkg::PROD_BITS;
    localparam int SB = dist_pkg::SUM_BITS;
    localparam int RB = dist_pkg::RND_BITS;

    logic [dist_pkg::CFG_BITS-1:0] drive_reg;
    logic [dist_pkg::CFG_BITS-1:0] tone_reg;
    logic [dist_pkg::CFG_BITS-1:0] level_reg;

    dist_pkg::sample_t     x_reg;
    dist_pkg::ch_addr_t    ch_reg;
    logic                  in_range_reg;
    logic signed [PB-1:0]  prod_reg;
    logic signed [PB-1:0]  acc_reg;
    dist_pkg::sample_t     p_reg;
    dist_pkg::sample_t     c_reg;
    dist_pkg::sample_t     t_reg;
    logic [20:0]           gain_reg;
    logic [16:0]           alpha_reg;
    logic [16:0]           beta_reg;

    logic signed [dist_pkg::MUL_A_BITS-1:0] mul_a;
    logic signed [dist_pkg::MUL_B_BITS-1:0] mul_b;
    logic signed [PB-1:0]                   mul_full;
    logic signed [SB-1:0]                   acc_sum;
    logic signed [RB-1:0]                   sum_rnd;
    logic signed [RB-1:0]                   prod_rnd;
    logic signed [RB-1:0]                   alpha_sum;
    dist_pkg::sample_t                      filt_sat;
    logic [16:0]                            alpha_next;
    dist_pkg::sample_t                      clip_next;
    logic [20:0]                            gain_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drive_reg <= dist_pkg::CFG_BITS'(16384);
            tone_reg  <= dist_pkg::CFG_BITS'(16384);
            level_reg <= dist_pkg::CFG_BITS'(32768);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dist_pkg::CFG_DRIVE: drive_reg <= cfg_wdata;
                dist_pkg::CFG_TONE:  tone_reg  <= cfg_wdata;
                dist_pkg::CFG_LEVEL: level_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.state)
            dist_pkg::ST_M1:
            begin
                mul_a = {x_reg[dist_pkg::SAMPLE_BITS-1], x_reg};
                mul_b = dist_pkg::MUL_B_BITS'(dist_pkg::PRE_X_COEF);
            end
            dist_pkg::ST_M2:
            begin
                mul_a = {pre_rdata[dist_pkg::SAMPLE_BITS-1], pre_rdata};
                mul_b = dist_pkg::MUL_B_BITS'(dist_pkg::PRE_P_COEF);
            end
            dist_pkg::ST_M3:
            begin
                mul_a = {1'b0, tone_reg};
                mul_b = dist_pkg::MUL_B_BITS'(dist_pkg::ALPHA_SLOPE);
            end
            dist_pkg::ST_M4:
            begin
                mul_a = {p_reg[dist_pkg::SAMPLE_BITS-1], p_reg};
                mul_b = {2'b00, gain_reg};
            end
            dist_pkg::ST_M5:
            begin
                mul_a = {tone_rdata[dist_pkg::SAMPLE_BITS-1], tone_rdata};
                mul_b = {6'b0, beta_reg};
            end
            dist_pkg::ST_M6:
            begin
                mul_a = {c_reg[dist_pkg::SAMPLE_BITS-1], c_reg};
                mul_b = {6'b0, alpha_reg};
            end
            dist_pkg::ST_M8:
            begin
                mul_a = {t_reg[dist_pkg::SAMPLE_BITS-1], t_reg};
                mul_b = {7'b0, level_reg};
            end
            default: ;
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // post-multiply arithmetic
    assign acc_sum   = {acc_reg[PB-1], acc_reg} + {prod_reg[PB-1], prod_reg};
    assign sum_rnd   = dist_pkg::round_q15(acc_sum);
    assign filt_sat  = dist_pkg::sat_sample(sum_rnd);
    assign prod_rnd  = dist_pkg::round_q15({prod_reg[PB-1], prod_reg});
    assign alpha_sum = prod_rnd + RB'(dist_pkg::ALPHA_BASE);
    assign gain_next = 21'(dist_pkg::UNITY_Q15) + 21'(dist_pkg::GAIN_SLOPE * drive_reg);

    always_comb
    begin
        if (alpha_sum > RB'(dist_pkg::UNITY_Q15))
            alpha_next = 17'(dist_pkg::UNITY_Q15);
        else
            alpha_next = alpha_sum[16:0];
    end

    always_comb
    begin
        if (prod_rnd > RB'(dist_pkg::CLIP_LIMIT))
            clip_next = dist_pkg::SAMPLE_BITS'(dist_pkg::CLIP_LIMIT);
        else if (prod_rnd < -RB'(dist_pkg::CLIP_LIMIT))
            clip_next = -dist_pkg::SAMPLE_BITS'(dist_pkg::CLIP_LIMIT);
        else
            clip_next = prod_rnd[dist_pkg::SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            x_reg        <= in_sample;
            ch_reg       <= in_channel[dist_pkg::CH_BITS-1:0];
            in_range_reg <= {1'b0, in_channel}
                            < (dist_pkg::CH_IN_BITS + 1)'(dist_pkg::MAX_CHANNELS);
        end
        // product holds while the result waits at the output
        if (ctrl.state != dist_pkg::ST_IDLE && ctrl.state != dist_pkg::ST_OUT)
        begin
            prod_reg <= mul_full;
        end
        case (ctrl.state)
            dist_pkg::ST_M2: acc_reg <= prod_reg;
            dist_pkg::ST_M3:
            begin
                p_reg    <= filt_sat;
                gain_reg <= gain_next;
            end
            dist_pkg::ST_M4:
            begin
                alpha_reg <= alpha_next;
                beta_reg  <= 17'(dist_pkg::UNITY_Q15) - alpha_next;
            end
            dist_pkg::ST_M5: c_reg   <= clip_next;
            dist_pkg::ST_M6: acc_reg <= prod_reg;
            dist_pkg::ST_M7: t_reg   <= filt_sat;
            default: ;
        endcase
    end

    assign wr.pre_we  = (ctrl.state == dist_pkg::ST_M3) && in_range_reg;
    assign wr.tone_we = (ctrl.state == dist_pkg::ST_M7) && in_range_reg;
    assign wr.addr    = ch_reg;
    assign wr.data    = filt_sat;

    assign result = in_range_reg ? dist_pkg::sat_sample(prod_rnd) : '0;

endmodule

// ===== sv/distortion_effect_channel_unit.sv =====
// ----------------------------------------------------------------------------
// distortion_effect_channel_unit
// Hard-clip distortion with per-channel pre and tone one-pole filters.
// ----------------------------------------------------------------------------
// Input stream s_*: one item = channel number plus a Q1.15 sample.
// Output stream m_*: one item = the processed, saturated Q1.15 sample.
// Settings (drive, tone, output level) are written through cfg_we/cfg_index/
// cfg_wdata; index 3 is ignored. The user must write them only while the
// unit is idle; the block does not enforce this. Each item reads its channel's
// two filter memories, then runs eight steps through one shared 17x23
// multiplier; the result is loaded into the output register in ST_OUT and
// the unit goes idle before taking the next item; the multiplier sets the rate.
// s_tready is high only between items. A finished result sits in the output
// register; while the receiver stalls the unit can finish one further item
// and then holds it until the output register frees up.
// Reset restores the default settings and makes all filter memories read as
// zero at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module distortion_effect_channel_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [2:0] channel, [18:3] sample_in, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample_out
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    dist_pkg::dist_state_t  state_reg;
    dist_pkg::dist_state_t  state_next;
    dist_pkg::dist_ctrl_t   ctrl;
    dist_pkg::dist_mem_wr_t wr;
    dist_pkg::sample_t      pre_rdata;
    dist_pkg::sample_t      tone_rdata;
    dist_pkg::sample_t      result;
    dist_pkg::sample_t      m_data_reg;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic                   accept;
    logic                   out_load;
    logic [2:0]             in_channel;
    dist_pkg::sample_t      in_sample;

    assign in_channel = s_tdata[2:0];
    assign in_sample  = s_tdata[18:3];

    assign s_tready = (state_reg == dist_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_load = (state_reg == dist_pkg::ST_OUT) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dist_pkg::ST_IDLE: if (s_tvalid) state_next = dist_pkg::ST_M1;
            dist_pkg::ST_M1:   state_next = dist_pkg::ST_M2;
            dist_pkg::ST_M2:   state_next = dist_pkg::ST_M3;
            dist_pkg::ST_M3:   state_next = dist_pkg::ST_M4;
            dist_pkg::ST_M4:   state_next = dist_pkg::ST_M5;
            dist_pkg::ST_M5:   state_next = dist_pkg::ST_M6;
            dist_pkg::ST_M6:   state_next = dist_pkg::ST_M7;
            dist_pkg::ST_M7:   state_next = dist_pkg::ST_M8;
            dist_pkg::ST_M8:   state_next = dist_pkg::ST_OUT;
            dist_pkg::ST_OUT:  if (out_load) state_next = dist_pkg::ST_IDLE;
            default:           state_next = dist_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dist_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= result;
        end
    end

    assign ctrl.state  = state_reg;
    assign ctrl.accept = accept;

    dist_mem u_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (accept),
        .rd_addr    (in_channel[dist_pkg::CH_BITS-1:0]),
        .wr         (wr),
        .pre_rdata  (pre_rdata),
        .tone_rdata (tone_rdata)
    );

    dist_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .ctrl       (ctrl),
        .in_channel (in_channel),
        .in_sample  (in_sample),
        .pre_rdata  (pre_rdata),
        .tone_rdata (tone_rdata),
        .wr         (wr),
        .result     (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == dist_pkg::ST_M1)
        else $error("accepted item did not start the multiply sequence");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && !m_tready |=> $stable(m_data_reg))
        else $error("waiting result overwritten");

    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr.pre_we && wr.tone_we))
        else $error("both filter memories written in one cycle");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hard-clip distortion channel unit.
// ----------------------------------------------------------------------------
// A short list of directed items and settings runs first: reset values,
// full-scale samples, zero level, drive and tone above 1.0, the unused
// register index. Random phases follow, each with new settings. Every
// accepted item goes through a bit-exact software copy of the filter chain
// and its per-channel memories; output items are checked in order against
// the queue of predicted samples. Both stream sides idle at random, but for one steady phase.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          PHASE_ITEMS   = 250;
    localparam int          NUM_PHASES    = 6;
    localparam int          NUM_ROWS      = 29;
    localparam logic [1:0]  CFG_UNUSED    = 2'd3;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [2:0]         ch;
        logic [1:0]         idx;
        logic [15:0]        value;
        logic               known;
        dist_pkg::sample_t  result;
    } stim_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    // predictor state
    logic [15:0]        drive_q15;
    logic [15:0]        tone_q15;
    logic [15:0]        level_q15;
    dist_pkg::sample_t  pre_mem [dist_pkg::MAX_CHANNELS];
    dist_pkg::sample_t  tone_mem [dist_pkg::MAX_CHANNELS];

    dist_pkg::sample_t  expected_samples [$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    int          stall_left  = 0;
    bit          steady      = 1'b0;
    logic [2:0]  last_ch     = '0;

    // kind/channel/index/value/known/result; known rows carry a hand-derived output
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_ITEM, 3'd0, dist_pkg::CFG_DRIVE, 16'h0000, 1'b1, 16'sh0000},
        '{ROW_ITEM, 3'd7, dist_pkg::CFG_DRIVE, 16'h0000, 1'b1, 16'sh0000},
        '{ROW_ITEM, 3'd0, dist_pkg::CFG_DRIVE, 16'h7FFF, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd0, dist_pkg::CFG_DRIVE, 16'h8000, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd1, dist_pkg::CFG_DRIVE, 16'h0001, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd1, dist_pkg::CFG_DRIVE, 16'hFFFF, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd2, dist_pkg::CFG_DRIVE, 16'h5555, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd5, dist_pkg::CFG_DRIVE, 16'hAAAA, 1'b0, 16'sh0000},
        '{ROW_CFG,  3'd0, dist_pkg::CFG_LEVEL, 16'h0000, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd3, dist_pkg::CFG_DRIVE, 16'h7FFF, 1'b1, 16'sh0000},
        '{ROW_ITEM, 3'd4, dist_pkg::CFG_DRIVE, 16'h8000, 1'b1, 16'sh0000},
        '{ROW_CFG,  3'd0, dist_pkg::CFG_DRIVE, 16'hFFFF, 1'b0, 16'sh0000},
        '{ROW_CFG,  3'd0, dist_pkg::CFG_TONE,  16'hFFFF, 1'b0, 16'sh0000},
        '{ROW_CFG,  3'd0, dist_pkg::CFG_LEVEL, 16'hFFFF, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd6, dist_pkg::CFG_DRIVE, 16'h7FFF, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd6, dist_pkg::CFG_DRIVE, 16'h8000, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd6, dist_pkg::CFG_DRIVE, 16'h7FFF, 1'b0, 16'sh0000},
        '{ROW_CFG,  3'd0, CFG_UNUSED,          16'h1234, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd6, dist_pkg::CFG_DRIVE, 16'h0064, 1'b0, 16'sh0000},
        '{ROW_CFG,  3'd0, dist_pkg::CFG_DRIVE, 16'h0000, 1'b0, 16'sh0000},
        '{ROW_CFG,  3'd0, dist_pkg::CFG_TONE,  16'h0000, 1'b0, 16'sh0000},
        '{ROW_CFG,  3'd0, dist_pkg::CFG_LEVEL, 16'h8000, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd0, dist_pkg::CFG_DRIVE, 16'h7FFF, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd0, dist_pkg::CFG_DRIVE, 16'h8000, 1'b0, 16'sh0000},
        '{ROW_CFG,  3'd0, dist_pkg::CFG_DRIVE, 16'h8000, 1'b0, 16'sh0000},
        '{ROW_CFG,  3'd0, dist_pkg::CFG_TONE,  16'h8000, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd7, dist_pkg::CFG_DRIVE, 16'h8000, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd7, dist_pkg::CFG_DRIVE, 16'h7FFF, 1'b0, 16'sh0000},
        '{ROW_ITEM, 3'd3, dist_pkg::CFG_DRIVE, 16'h04D2, 1'b0, 16'sh0000}
    };

    distortion_effect_channel_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // round to nearest, ties toward +inf
    function automatic longint q15_round(input longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic dist_pkg::sample_t clamp_sample(input longint v);
        if (v > dist_pkg::SMP_MAX)
            return dist_pkg::sample_t'(dist_pkg::SMP_MAX);
        if (v < dist_pkg::SMP_MIN)
            return dist_pkg::sample_t'(dist_pkg::SMP_MIN);
        return dist_pkg::sample_t'(v);
    endfunction

    function automatic dist_pkg::sample_t predict_distortion(input logic [2:0] ch,
                                                             input dist_pkg::sample_t x);
        longint pre;
        longint boosted;
        longint clipped;
        longint alpha;
        longint toned;
        pre = clamp_sample(q15_round(longint'(dist_pkg::PRE_X_COEF) * x
                                     + longint'(dist_pkg::PRE_P_COEF) * pre_mem[ch]));
        pre_mem[ch] = dist_pkg::sample_t'(pre);
        boosted = q15_round(pre * (longint'(dist_pkg::UNITY_Q15)
                                   + longint'(dist_pkg::GAIN_SLOPE) * longint'(drive_q15)));
        clipped = boosted;
        if (clipped > dist_pkg::CLIP_LIMIT)
            clipped = dist_pkg::CLIP_LIMIT;
        if (clipped < -dist_pkg::CLIP_LIMIT)
            clipped = -dist_pkg::CLIP_LIMIT;
        // tone above 1.0 pins alpha at unity
        alpha = dist_pkg::ALPHA_BASE
                + q15_round(longint'(dist_pkg::ALPHA_SLOPE) * longint'(tone_q15));
        if (alpha > dist_pkg::UNITY_Q15)
            alpha = dist_pkg::UNITY_Q15;
        toned = clamp_sample(q15_round(alpha * clipped
                                       + (dist_pkg::UNITY_Q15 - alpha) * tone_mem[ch]));
        tone_mem[ch] = dist_pkg::sample_t'(toned);
        return clamp_sample(q15_round(toned * longint'(level_q15)));
    endfunction

    // ------------------------------------------------------------------ helpers

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic [2:0] ch, input dist_pkg::sample_t smp,
                             input logic known, input dist_pkg::sample_t fixed_val);
        dist_pkg::sample_t predicted;
        int                gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, smp, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_distortion(ch, smp);
        expected_samples.push_back(known ? fixed_val : predicted);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off the sender until every predicted item has come out
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            dist_pkg::CFG_DRIVE: drive_q15 = val;
            dist_pkg::CFG_TONE:  tone_q15  = val;
            dist_pkg::CFG_LEVEL: level_q15 = val;
            default:             ;
        endcase
    endtask

    function automatic dist_pkg::sample_t random_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return dist_pkg::sample_t'($urandom());
        if (r < 85)
        begin
            case ($urandom_range(0, 2))
                0:       return dist_pkg::sample_t'(dist_pkg::SMP_MAX);
                1:       return dist_pkg::sample_t'(dist_pkg::SMP_MIN);
                default: return '0;
            endcase
        end
        return dist_pkg::sample_t'($signed($urandom_range(0, 400)) - 200);
    endfunction

    function automatic logic [15:0] random_setting();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------ receive side

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 99) < 25)
        begin
            stall_left <= pick_gap();
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        dist_pkg::sample_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, got %0d",
                         $time, $signed(m_tdata));
                mismatches++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (m_tdata !== want)
                begin
                    $display("%0t: sample_out mismatch, expected %0d, got %0d",
                             $time, want, $signed(m_tdata));
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    initial
    begin
        logic [15:0] phase_drive;
        logic [15:0] phase_tone;
        logic [15:0] phase_level;
        logic [2:0]  ch;

        drive_q15 = 16'd16384;
        tone_q15  = 16'd16384;
        level_q15 = 16'd32768;
        for (int i = 0; i < dist_pkg::MAX_CHANNELS; i++)
        begin
            pre_mem[i]  = '0;
            tone_mem[i] = '0;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                drain_stream();
                write_reg(directed_rows[i].idx, directed_rows[i].value);
            end
            else
                send_item(directed_rows[i].ch,
                          dist_pkg::sample_t'(directed_rows[i].value),
                          directed_rows[i].known, directed_rows[i].result);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    phase_drive = 16'h0000;
                    phase_tone  = 16'h0000;
                    phase_level = 16'hFFFF;
                end
                1:
                begin
                    phase_drive = 16'hFFFF;
                    phase_tone  = 16'hFFFF;
                    phase_level = 16'h0001;
                end
                default:
                begin
                    phase_drive = random_setting();
                    phase_tone  = random_setting();
                    phase_level = random_setting();
                end
            endcase
            drain_stream();
            steady = (ph == 3);
            write_reg(dist_pkg::CFG_DRIVE, phase_drive);
            write_reg(dist_pkg::CFG_TONE, phase_tone);
            write_reg(dist_pkg::CFG_LEVEL, phase_level);
            write_reg(CFG_UNUSED, 16'($urandom()));

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // bursts on one channel let the filter memories build up
                if ($urandom_range(0, 99) < 40)
                    last_ch = 3'($urandom_range(0, 7));
                ch = last_ch;
                send_item(ch, random_sample(), 1'b0, '0);
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    drain_stream();
            end
        end

        drain_stream();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
